FILE: sv/vas_pkg.sv
// Shared types and constants of the valve action scheduler.
package vas_pkg;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_DECIDE = 2'd1;
    localparam logic [1:0] OP_MOVE_END = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [3:0] VS_UNKNOWN = 4'd0;
    localparam logic [3:0] VS_FAILED = 4'd1;
    localparam logic [3:0] VS_BLOCKED = 4'd2;
    localparam logic [3:0] VS_FULL_OPEN = 4'd3;
    localparam logic [3:0] VS_OPEN_CIRC = 4'd4;
    localparam logic [3:0] VS_IDLE = 4'd5;
    localparam logic [3:0] VS_PRESENT = 4'd6;

    localparam int FB_FORCED = 0;
    localparam int FB_RETRY = 1;
    localparam int FB_EARLY = 2;
    localparam int FB_CALIB = 3;
    localparam int FB_TIMED = 4;
    localparam int FB_CALIBRATED = 5;
    localparam int FB_RECAL = 6;
    localparam int FB_TOUCHED = 7;
    localparam int FB_LEASE = 8;
    localparam int FB_SVC_HOLD = 9;
    localparam int FB_BLK_FS = 10;
    localparam int FB_NEED_REF = 11;

    localparam logic [2:0] AK_NONE = 3'd0;
    localparam logic [2:0] AK_TEST = 3'd1;
    localparam logic [2:0] AK_OPEN_END = 3'd2;
    localparam logic [2:0] AK_CLOSE_END = 3'd3;
    localparam logic [2:0] AK_OPEN = 3'd4;
    localparam logic [2:0] AK_CLOSE = 3'd5;
    localparam logic [2:0] AK_LEARN = 3'd6;
    localparam logic [2:0] AK_MARK = 3'd7;

    localparam logic [2:0] SR_END_STOP = 3'd1;
    localparam logic [2:0] SR_EARLY_END = 3'd2;
    localparam logic [2:0] SR_OVERCURRENT = 3'd3;

    localparam logic [6:0] POS_FULL = 7'd100;
    localparam logic [6:0] POS_HALF = 7'd50;
    localparam logic [3:0] FAIR_RESET = 4'd4;
    localparam logic [2:0] REG_FAIRNESS = 3'd0;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  valve;
        logic [3:0]  valve_status;
        logic [6:0]  drive_target;
        logic [6:0]  actual_position;
        logic [11:0] request_flags;
        logic        safe_mode;
        logic        temperature_hold;
        logic [2:0]  stop_reason;
        logic        early_stop;
        logic [3:0]  end_status;
    } t_in_word;

    typedef struct packed {
        logic [2:0] action_kind;
        logic [3:0] target_valve;
        logic [6:0] move_delta;
        logic       keep_status;
        logic       reference_run;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_PICK
    } t_state;

    typedef struct packed {
        logic apply;
        logic start;
        logic eval;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

FILE: sv/vas_ctrl.sv
// Sequencer of the valve action scheduler.
module vas_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_is_decide,
    input  vas_pkg::t_status i_status,
    output logic             o_in_stall,
    output vas_pkg::t_cmd    o_cmd
);
    import vas_pkg::*;

    t_state r_state, n_state;
    logic   acc;

    assign acc = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc && i_is_decide) n_state = S_EVAL;
            end
            S_EVAL: n_state = S_PICK;
            S_PICK: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = 1'b1;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.apply = acc && !i_is_decide;
                o_cmd.start = acc && i_is_decide;
            end
            S_EVAL: o_cmd.eval = 1'b1;
            S_PICK: o_cmd.commit = !i_status.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: sv/vas_dpath.sv
// Valve views, latches, pending moves, round-robin pick and result register.
module vas_dpath #(
    parameter int VALVE_COUNT = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vas_pkg::t_cmd      i_cmd,
    input  vas_pkg::t_in_word  i_word,
    input  logic [3:0]         i_fair_limit,
    input  logic               i_out_stall,
    output vas_pkg::t_status   o_status,
    output logic               o_out_valid,
    output vas_pkg::t_out_word o_out_word
);
    import vas_pkg::*;

    localparam int IW = $clog2(VALVE_COUNT);
    localparam int N = VALVE_COUNT;

    logic [3:0]  r_vs [N];
    logic [6:0]  r_vd [N];
    logic [6:0]  r_va [N];
    logic [11:0] r_vf [N];

    logic        r_lv [N];
    logic        r_ldir [N];
    logic [6:0]  r_ldrv [N];
    logic [3:0]  r_lst [N];
    logic        r_lret [N];

    logic        r_pv [N];
    logic        r_pdir [N];
    logic [6:0]  r_pdrv [N];
    logic        r_pkeep [N];
    logic        r_pref [N];

    logic [IW-1:0] r_probe, r_rr;
    logic [3:0]    r_mrc;
    logic          r_fcs, r_safe;
    logic [N-1:0]  r_mv, r_ln;
    logic          r_out_valid;
    t_out_word     r_out_word;

    logic [N-1:0] c_fo, c_oc, c_bk, c_rf, c_mm, c_pr, c_lc, c_mis, c_dir;

    always_comb begin
        logic flt, expl, anyr, pcal, due, hold, nref, diff, alw;
        for (int i = 0; i < N; i++) begin
            flt  = r_vs[i] == VS_FAILED || r_vs[i] == VS_BLOCKED;
            expl = flt ? (r_vf[i][FB_FORCED] | r_vf[i][FB_RETRY])
                       : (r_vf[i][FB_FORCED] | r_vf[i][FB_RETRY] |
                          r_vf[i][FB_EARLY] | r_vf[i][FB_CALIB]);
            anyr = expl || (r_vf[i][FB_TIMED] && !flt);
            pcal = !r_vf[i][FB_CALIBRATED] || r_vf[i][FB_RECAL];
            diff = r_vd[i] != r_va[i];
            due  = diff || r_vf[i][FB_TOUCHED] || r_vf[i][FB_LEASE];
            hold = r_vf[i][FB_SVC_HOLD];
            nref = r_vf[i][FB_NEED_REF];
            c_dir[i] = r_vd[i] > r_va[i];
            c_mis[i] = r_lv[i] && (r_ldrv[i] != r_vd[i] || r_lst[i] != r_vs[i]);
            alw  = !r_lv[i] || c_mis[i] || (c_dir[i] != r_ldir[i]) || r_lret[i];
            c_fo[i] = r_vs[i] == VS_FULL_OPEN;
            c_oc[i] = r_vs[i] == VS_OPEN_CIRC && diff;
            c_bk[i] = r_vs[i] == VS_BLOCKED && r_vf[i][FB_BLK_FS] && !hold && !anyr &&
                      diff && alw;
            c_rf[i] = r_vs[i] == VS_IDLE && !hold && !pcal && !anyr && nref && due;
            c_mm[i] = r_vs[i] == VS_IDLE && !hold && !pcal && !anyr && !nref && diff && alw;
            c_pr[i] = r_vs[i] == VS_PRESENT && (r_fcs || expl || due);
            c_lc[i] = r_vs[i] == VS_IDLE && pcal && !hold && due;
        end
    end

    logic [N-1:0] c_mp;
    always_comb begin
        logic flt, expl, anyr;
        for (int i = 0; i < N; i++) begin
            flt  = r_vs[i] == VS_FAILED || r_vs[i] == VS_BLOCKED;
            expl = flt ? (r_vf[i][FB_FORCED] | r_vf[i][FB_RETRY])
                       : (r_vf[i][FB_FORCED] | r_vf[i][FB_RETRY] |
                          r_vf[i][FB_EARLY] | r_vf[i][FB_CALIB]);
            anyr = expl || (r_vf[i][FB_TIMED] && !flt);
            c_mp[i] = anyr && r_vs[i] != VS_UNKNOWN && r_vs[i] != VS_PRESENT;
        end
    end

    function automatic logic [IW-1:0] rr_pick(input logic [N-1:0] vec,
                                              input logic [IW-1:0] ptr);
        logic [IW-1:0] idx_hi, idx_all;
        logic          hi;
        idx_hi  = '0;
        idx_all = '0;
        hi      = 1'b0;
        for (int k = N - 1; k >= 0; k--) begin
            if (vec[k]) begin
                idx_all = IW'(k);
                if (IW'(k) >= ptr) begin
                    idx_hi = IW'(k);
                    hi     = 1'b1;
                end
            end
        end
        return hi ? idx_hi : idx_all;
    endfunction

    logic [IW-1:0] t, j, j_next, nt;
    logic [IW:0]   nt_sum;
    logic          probe_unk, learn_first, do_test, do_move, do_learn, busy;
    logic          sm_dir;
    t_out_word     res;

    assign busy = r_out_valid && i_out_stall;
    assign o_status.out_busy = busy;

    always_comb begin
        t           = r_probe;
        probe_unk   = r_vs[t] == VS_UNKNOWN;
        nt_sum      = {1'b0, t} + (IW+1)'(2);
        if (nt_sum == (IW+1)'(N)) nt = IW'(1);
        else if (nt_sum > (IW+1)'(N)) nt = '0;
        else nt = nt_sum[IW-1:0];
        do_test     = !r_safe && probe_unk;
        learn_first = !r_safe && !probe_unk && (r_mrc >= i_fair_limit) && (|r_ln);
        do_move     = !r_safe && !probe_unk && !learn_first && (|r_mv);
        do_learn    = learn_first || (!r_safe && !probe_unk && !do_move && (|r_ln));
        j           = do_move ? rr_pick(r_mv, r_rr) : rr_pick(r_ln, r_rr);
        j_next      = (j == IW'(N - 1)) ? '0 : j + IW'(1);
        sm_dir      = c_dir[j];
        res         = '0;
        if (do_test) begin
            res.action_kind  = AK_TEST;
            res.target_valve = 4'(t);
        end else if (do_learn) begin
            res.action_kind  = (c_pr[j] || c_lc[j]) ? AK_LEARN : AK_MARK;
            res.target_valve = 4'(j);
        end else if (do_move) begin
            res.target_valve = 4'(j);
            if (c_fo[j]) begin
                res.action_kind = AK_OPEN_END;
            end else if (c_oc[j]) begin
                res.action_kind = AK_TEST;
            end else if (c_rf[j]) begin
                res.action_kind   = (r_vd[j] >= POS_HALF) ? AK_OPEN_END : AK_CLOSE_END;
                res.reference_run = 1'b1;
            end else begin
                res.keep_status = c_bk[j];
                if (r_vd[j] == POS_FULL) res.action_kind = AK_OPEN_END;
                else if (r_vd[j] == 7'd0) res.action_kind = AK_CLOSE_END;
                else if (sm_dir) begin
                    res.action_kind = AK_OPEN;
                    res.move_delta  = r_vd[j] - r_va[j];
                end else begin
                    res.action_kind = AK_CLOSE;
                    res.move_delta  = r_va[j] - r_vd[j];
                end
            end
        end
    end

    logic          in_rng;
    logic [IW-1:0] v;
    logic          endstop;

    assign v       = i_word.valve[IW-1:0];
    assign in_rng  = 32'(i_word.valve) < N;
    assign endstop = i_word.stop_reason == SR_END_STOP ||
                     i_word.stop_reason == SR_EARLY_END ||
                     i_word.stop_reason == SR_OVERCURRENT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_vs[i] <= '0;
                r_vd[i] <= '0;
                r_va[i] <= '0;
                r_vf[i] <= '0;
                r_lv[i] <= 1'b0;
                r_pv[i] <= 1'b0;
            end
            r_probe     <= '0;
            r_rr        <= '0;
            r_mrc       <= '0;
            r_fcs       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.apply && in_rng) begin
                case (i_word.operation)
                    OP_UPDATE: begin
                        r_vs[v] <= i_word.valve_status;
                        r_vd[v] <= i_word.drive_target;
                        r_va[v] <= i_word.actual_position;
                        r_vf[v] <= i_word.request_flags;
                    end
                    OP_MOVE_END: begin
                        r_pv[v] <= 1'b0;
                        if (r_pv[v]) begin
                            if (r_pref[v] || !endstop) begin
                                r_lv[v] <= 1'b0;
                            end else if (r_lv[v] && r_ldir[v] == r_pdir[v] &&
                                         r_ldrv[v] == r_pdrv[v]) begin
                                r_lst[v] <= i_word.end_status;
                            end else begin
                                r_lv[v]   <= 1'b1;
                                r_ldir[v] <= r_pdir[v];
                                r_ldrv[v] <= r_pdrv[v];
                                r_lst[v]  <= i_word.end_status;
                                r_lret[v] <= i_word.early_stop && !r_pkeep[v];
                            end
                        end
                    end
                    OP_CLEAR: r_lv[v] <= 1'b0;
                    default: ;
                endcase
            end
            if (i_cmd.start) r_safe <= i_word.safe_mode | i_word.temperature_hold;
            if (i_cmd.eval) begin
                r_mv <= c_fo | c_oc | c_bk | c_rf | c_mm;
                r_ln <= c_pr | c_lc | c_mp;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                r_out_word  <= res;
                if (!r_safe) r_probe <= nt;
                if (do_test) r_lv[t] <= 1'b0;
                if (do_learn) begin
                    r_lv[j] <= 1'b0;
                    r_pv[j] <= 1'b0;
                    r_rr    <= j_next;
                    r_mrc   <= '0;
                    if (c_lc[j] || (c_pr[j] && r_vd[j] != r_va[j])) r_fcs <= 1'b1;
                end
                if (do_move) begin
                    r_rr <= j_next;
                    if (r_mrc < i_fair_limit) r_mrc <= r_mrc + 4'd1;
                    if (c_fo[j]) begin
                        r_pv[j]    <= 1'b1;
                        r_pdir[j]  <= 1'b1;
                        r_pdrv[j]  <= r_vd[j];
                        r_pkeep[j] <= 1'b0;
                        r_pref[j]  <= 1'b0;
                    end else if (c_oc[j]) begin
                        r_lv[j] <= 1'b0;
                    end else if (c_rf[j]) begin
                        r_lv[j]    <= 1'b0;
                        r_pv[j]    <= 1'b1;
                        r_pdir[j]  <= r_vd[j] >= POS_HALF;
                        r_pdrv[j]  <= r_vd[j];
                        r_pkeep[j] <= 1'b0;
                        r_pref[j]  <= 1'b1;
                        r_fcs      <= 1'b1;
                    end else begin
                        if (c_mis[j]) r_lv[j] <= 1'b0;
                        else if (r_lv[j] && r_ldir[j] == sm_dir) r_lret[j] <= 1'b0;
                        r_pv[j]    <= 1'b1;
                        r_pdir[j]  <= sm_dir;
                        r_pdrv[j]  <= r_vd[j];
                        r_pkeep[j] <= c_bk[j];
                        r_pref[j]  <= 1'b0;
                        if (c_mm[j]) r_fcs <= 1'b1;
                    end
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: sv/valve_action_scheduler_unit.sv
// Top level of the valve action scheduler: ports, register file, sequencer and datapath.
//  channel | direction | handshake                     | word
//  in      | input     | i_in_valid / o_in_stall       | t_in_word
//  out     | output    | o_out_valid / i_out_stall     | t_out_word
//  config  | input     | APB psel/penable/pwrite       | fairness_limit
// Update, move-ended and clear words take effect in the cycle they are accepted.
// A decide word is handled in steps: accept, evaluate all valves, then pick and commit.
// The commit waits while a previous result is held by a stalled output register.
// Synchronous active-low reset; views and valid bits cleared at once, no clearing pass.
module valve_action_scheduler_unit #(
    parameter int VALVE_COUNT = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  vas_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output vas_pkg::t_out_word o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import vas_pkg::*;

    logic [3:0] r_fair;
    t_cmd       cmd;
    t_status    status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fair <= FAIR_RESET;
        end else if (psel && penable && pwrite && paddr == REG_FAIRNESS) begin
            r_fair <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_FAIRNESS) ? {28'd0, r_fair} : 32'd0;

    vas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_is_decide (i_in_word.operation == OP_DECIDE),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    vas_dpath #(.VALVE_COUNT(VALVE_COUNT)) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_word       (i_in_word),
        .i_fair_limit (r_fair),
        .i_out_stall  (i_out_stall),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word)
    );

endmodule

FILE: sv/vas_checker.sv
// Port-level checks of the valve action scheduler, bound to the top level.
module vas_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input vas_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input vas_pkg::t_out_word o_out_word,
    input logic               pready
);
    import vas_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_decide_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_word.operation == OP_DECIDE |=> o_in_stall)
        else $error("decide word did not occupy the block");

    a_other_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_word.operation != OP_DECIDE |=> !o_in_stall)
        else $error("single-cycle word held the input");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.action_kind == AK_NONE |->
            o_out_word.target_valve == 4'd0 && o_out_word.move_delta == 7'd0)
        else $error("empty decision carries a valve or delta");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind valve_action_scheduler_unit vas_checker u_vas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word),
    .pready      (pready)
);
